### rtl/mfmr_pkg.sv
// ----------------------------------------------------------------------------
// mfmr_pkg
// Shared types and constants for the marker framed message receiver.
// ----------------------------------------------------------------------------
package mfmr_pkg;

	localparam int MESSAGE_BYTES_DEF = 64;

	localparam logic [7:0] START_MARKER_RST = 8'h3C;
	localparam logic [7:0] END_MARKER_RST   = 8'h3E;
	localparam logic [7:0] NUL_BYTE         = 8'h00;

	localparam logic CFG_START_MARKER = 1'b0;
	localparam logic CFG_END_MARKER   = 1'b1;

	localparam logic ACT_ARM  = 1'b0;
	localparam logic ACT_BYTE = 1'b1;

	typedef enum logic [2:0] {
		EV_ARMED    = 3'd0,
		EV_REJECTED = 3'd1,
		EV_IGNORED  = 3'd2,
		EV_STARTED  = 3'd3,
		EV_DATA     = 3'd4,
		EV_COMPLETE = 3'd5,
		EV_OVERFLOW = 3'd6
	} ev_t;

	typedef enum logic [1:0] {
		CLS_ARM   = 2'd0,
		CLS_START = 2'd1,
		CLS_END   = 2'd2,
		CLS_DATA  = 2'd3
	} cls_t;

	typedef struct packed {
		cls_t       kind;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		ev_t        event_kind;
		logic [7:0] data_out;
		logic [5:0] position;
		logic [5:0] message_length;
		logic       want_next_byte;
		logic       busy_res;
	} res_t;

endpackage

### rtl/mfmr_fifo.sv
// ----------------------------------------------------------------------------
// mfmr_fifo
// Two-entry queue with push/full and pop/empty, full rate on both sides.
// ----------------------------------------------------------------------------
module mfmr_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("fifo count out of range");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> !empty)
		else $error("pushed transaction not visible");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> !full)
		else $error("popped transaction did not free a slot");
`endif

endmodule

### rtl/mfmr_front.sv
// ----------------------------------------------------------------------------
// mfmr_front
// Holds the marker registers and classifies each incoming transaction.
// ----------------------------------------------------------------------------
module mfmr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [7:0]     cfg_data,
	input  logic           action,
	input  logic [7:0]     rx_byte,
	output mfmr_pkg::cmd_t cmd
);
	import mfmr_pkg::*;

	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_END_MARKER:   end_marker_q   <= cfg_data;
				default:          start_marker_q <= start_marker_q;
			endcase
		end
	end

	always_comb begin
		cmd.rx_byte = rx_byte;
		if (action == ACT_ARM) begin
			cmd.kind = CLS_ARM;
		end else if (rx_byte == start_marker_q) begin
			cmd.kind = CLS_START;
		end else if (rx_byte == end_marker_q || rx_byte == NUL_BYTE) begin
			cmd.kind = CLS_END;
		end else begin
			cmd.kind = CLS_DATA;
		end
	end

endmodule

### rtl/mfmr_back.sv
// ----------------------------------------------------------------------------
// mfmr_back
// Receive state and write position; turns each command into one result.
// ----------------------------------------------------------------------------
module mfmr_back #(
	parameter int MESSAGE_BYTES = mfmr_pkg::MESSAGE_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  mfmr_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           res_full,
	output logic           res_push,
	output mfmr_pkg::res_t res
);
	import mfmr_pkg::*;

	localparam int PosW = $clog2(MESSAGE_BYTES);
	localparam logic [PosW-1:0] Limit    = PosW'(MESSAGE_BYTES - 1);
	localparam logic [PosW+5:0] LimitExt = {6'b0, Limit};

	logic            receiving_q;
	logic            inside_q;
	logic [PosW-1:0] wpos_q;
	logic            receiving_d;
	logic            inside_d;
	logic [PosW-1:0] wpos_d;
	logic [PosW+5:0] wpos_ext;
	logic            fire;

	assign fire     = !cmd_empty && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;
	assign wpos_ext = {6'b0, wpos_q};

	always_comb begin
		receiving_d        = receiving_q;
		inside_d           = inside_q;
		wpos_d             = wpos_q;
		res.event_kind     = EV_IGNORED;
		res.data_out       = 8'd0;
		res.position       = 6'd0;
		res.message_length = 6'd0;
		res.want_next_byte = 1'b0;
		if (cmd.kind == CLS_ARM) begin
			if (receiving_q) begin
				res.event_kind = EV_REJECTED;
			end else begin
				receiving_d        = 1'b1;
				inside_d           = 1'b0;
				wpos_d             = '0;
				res.event_kind     = EV_ARMED;
				res.want_next_byte = 1'b1;
			end
		end else if (!receiving_q) begin
			res.event_kind = EV_IGNORED;
		end else begin
			case (cmd.kind)
				CLS_START: begin
					inside_d           = 1'b1;
					wpos_d             = '0;
					res.event_kind     = EV_STARTED;
					res.want_next_byte = 1'b1;
				end
				CLS_END: begin
					if (!inside_q) begin
						res.want_next_byte = 1'b1;
					end else begin
						inside_d           = 1'b0;
						receiving_d        = 1'b0;
						res.event_kind     = EV_COMPLETE;
						res.message_length = wpos_ext[5:0];
					end
				end
				default: begin
					if (!inside_q) begin
						res.want_next_byte = 1'b1;
					end else if (wpos_q < Limit) begin
						wpos_d             = wpos_q + 1'b1;
						res.event_kind     = EV_DATA;
						res.data_out       = cmd.rx_byte;
						res.position       = wpos_ext[5:0];
						res.want_next_byte = 1'b1;
					end else begin
						inside_d           = 1'b0;
						receiving_d        = 1'b0;
						res.event_kind     = EV_OVERFLOW;
						res.message_length = LimitExt[5:0];
					end
				end
			endcase
		end
		res.busy_res = receiving_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			inside_q    <= 1'b0;
			wpos_q      <= '0;
		end else if (fire) begin
			receiving_q <= receiving_d;
			inside_q    <= inside_d;
			wpos_q      <= wpos_d;
		end
	end

`ifndef SYNTHESIS
	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= Limit)
		else $error("write position past limit");

	a_busy_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> receiving_q == $past(res.busy_res))
		else $error("busy flag disagrees with receive state");

	a_inside_needs_rx: assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> receiving_q)
		else $error("inside message while not receiving");
`endif

endmodule

### rtl/marker_framed_message_receiver_core.sv
// ----------------------------------------------------------------------------
// marker_framed_message_receiver_core
// Start/end marker deframer for a byte-at-a-time serial receive.
// ----------------------------------------------------------------------------
// Input channel: push/full carrying action (arm or byte) and rx_byte. A
// transaction is taken at a clock edge with push high and full low.
// Result channel: empty/pop; the oldest result sits on event_kind, data_out,
// position, message_length, want_next_byte and busy_res while empty is low,
// and leaves at an edge with pop high.
// Config: cfg_we writes cfg_data into start marker (index 0) or end marker
// (index 1); write only while no transaction is in flight.
// Every input transaction yields exactly one result.
// A taken input is registered in the command queue, turned into a result
// by the back end and registered in the result queue, where it is visible.
// Throughput: one transaction per cycle while the result queue has room, set
// by the state update in the back end; each side has a two-entry queue.
// Reset clears the receive state and queues and restores the markers to
// '<' and '>'. If pop stays low, the result queue fills, the back end
// stalls, then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module marker_framed_message_receiver_core #(
	parameter int MESSAGE_BYTES = mfmr_pkg::MESSAGE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] event_kind,
	output logic [7:0] data_out,
	output logic [5:0] position,
	output logic [5:0] message_length,
	output logic       want_next_byte,
	output logic       busy_res
);
	import mfmr_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_out;
	res_t res_in;
	res_t res_out;
	logic cmd_empty;
	logic cmd_pop;
	logic res_full;
	logic res_push;

	mfmr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.action    (action),
		.rx_byte   (rx_byte),
		.cmd       (cmd_in)
	);

	mfmr_fifo #(
		.WIDTH ($bits(cmd_t))
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (cmd_out)
	);

	mfmr_back #(
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	mfmr_fifo #(
		.WIDTH ($bits(res_t))
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_in),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_out)
	);

	assign event_kind     = res_out.event_kind;
	assign data_out       = res_out.data_out;
	assign position       = res_out.position;
	assign message_length = res_out.message_length;
	assign want_next_byte = res_out.want_next_byte;
	assign busy_res       = res_out.busy_res;

endmodule
